// ===== design/skse_pkg.sv =====
// Shared constants, codes and types for the sorted key set engine.
`timescale 1ns / 1ps

package skse_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int KEY_BITS_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int KEY_IN_W = 32;
    localparam int IDX_W    = 9;
    localparam int ST_W     = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [ST_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;
    localparam logic [ST_W-1:0] ST_RANGE     = 3'd5;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] count;
    } t_result;

endpackage

// ===== design/skse_if.sv =====
// Request and result channel interfaces of the sorted key set engine.
`timescale 1ns / 1ps

interface skse_req_if;
    logic                          valid;
    logic                          ready;
    logic [skse_pkg::CMD_W-1:0]    command;
    logic [skse_pkg::KEY_IN_W-1:0] key;
    logic [skse_pkg::IDX_W-1:0]    start_index;
    logic [skse_pkg::IDX_W-1:0]    remove_count;

    modport source (output valid, command, key, start_index, remove_count, input ready);
    modport sink   (input valid, command, key, start_index, remove_count, output ready);
endinterface

interface skse_res_if;
    logic                       valid;
    logic                       ready;
    logic [skse_pkg::ST_W-1:0]  status;
    logic [skse_pkg::IDX_W-1:0] index;
    logic [skse_pkg::IDX_W-1:0] count;

    modport source (output valid, status, index, count, input ready);
    modport sink   (input valid, status, index, count, output ready);
endinterface

// ===== design/skse_key_store.sv =====
// Key store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module skse_key_store #(
    parameter int DEPTH = skse_pkg::CAPACITY_DEF,
    parameter int WIDTH = skse_pkg::KEY_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/skse_ctrl.sv =====
// Sequencer: binary search probes and entry moves through the key store.
`timescale 1ns / 1ps

module skse_ctrl #(
    parameter int CAPACITY = skse_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = skse_pkg::KEY_BITS_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic [skse_pkg::CMD_W-1:0]    i_command,
    input  logic [skse_pkg::KEY_IN_W-1:0] i_key,
    input  logic [skse_pkg::IDX_W-1:0]    i_start,
    input  logic [skse_pkg::IDX_W-1:0]    i_len,
    output logic                          o_res_valid,
    input  logic                          i_res_take,
    output skse_pkg::t_result             o_res,
    output logic                          o_rd_en,
    output logic [AW-1:0]                 o_rd_addr,
    input  logic [KEY_BITS-1:0]           i_rd_data,
    output logic                          o_wr_en,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [KEY_BITS-1:0]           o_wr_data
);

    localparam int EW = ((CW > skse_pkg::IDX_W) ? CW : skse_pkg::IDX_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SRCH_RD  = 5'b00010,
        S_SRCH_CMP = 5'b00100,
        S_SHIFT    = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic [skse_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [KEY_BITS-1:0]        r_key, n_key;
    logic [skse_pkg::IDX_W-1:0] r_len, n_len;
    logic [CW-1:0]              r_lo, n_lo;
    logic [CW-1:0]              r_hi, n_hi;
    logic [CW-1:0]              r_ins, n_ins;
    logic [AW-1:0]              r_mid, n_mid;
    logic [CW-1:0]              r_count, n_count;
    logic [skse_pkg::ST_W-1:0]  r_status, n_status;
    logic [CW-1:0]              r_index, n_index;
    logic [AW-1:0]              r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]              r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]              r_moves, n_moves;
    logic                       r_pend, n_pend;
    logic                       r_up, n_up;

    logic [CW-1:0] w_mid;
    logic [EW-1:0] w_end;

    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);
    assign w_end = EW'(i_start) + EW'(i_len);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_len     = r_len;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_ins     = r_ins;
        n_mid     = r_mid;
        n_count   = r_count;
        n_status  = r_status;
        n_index   = r_index;
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_moves   = r_moves;
        n_pend    = r_pend;
        n_up      = r_up;
        o_rd_en   = 1'b0;
        o_rd_addr = r_rd_ptr;
        o_wr_en   = 1'b0;
        o_wr_addr = r_wr_ptr;
        o_wr_data = i_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_cmd    = i_command;
                    n_key    = KEY_BITS'(i_key);
                    n_len    = i_len;
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_ins    = '0;
                    n_index  = '0;
                    n_status = skse_pkg::ST_RANGE;
                    unique case (i_command) inside
                        skse_pkg::CMD_INSERT, skse_pkg::CMD_LOOKUP: begin
                            n_state = S_SRCH_RD;
                        end
                        skse_pkg::CMD_REMOVE: begin
                            if (i_len == '0) begin
                                n_status = skse_pkg::ST_ADDED;
                                n_state  = S_DONE;
                            end else if (w_end > EW'(r_count)) begin
                                n_state = S_DONE;
                            end else begin
                                // entries above the run slide down onto it
                                n_status = skse_pkg::ST_ADDED;
                                n_rd_ptr = AW'(w_end);
                                n_wr_ptr = AW'(i_start);
                                n_moves  = CW'(EW'(r_count) - w_end);
                                n_up     = 1'b0;
                                n_pend   = 1'b0;
                                n_state  = S_SHIFT;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(w_mid);
                    n_mid     = AW'(w_mid);
                    n_state   = S_SRCH_CMP;
                end else if (r_cmd == skse_pkg::CMD_LOOKUP) begin
                    n_status = skse_pkg::ST_NOT_FOUND;
                    n_index  = '0;
                    n_state  = S_DONE;
                end else if (r_count == CW'(CAPACITY)) begin
                    n_status = skse_pkg::ST_FULL;
                    n_index  = '0;
                    n_state  = S_DONE;
                end else begin
                    // open a hole at the insertion point, top entry first
                    n_status = skse_pkg::ST_ADDED;
                    n_index  = r_ins;
                    n_rd_ptr = AW'(r_count - CW'(1));
                    n_wr_ptr = AW'(r_count);
                    n_moves  = r_count - r_ins;
                    n_up     = 1'b1;
                    n_pend   = 1'b0;
                    n_state  = S_SHIFT;
                end
            end

            S_SRCH_CMP: begin
                if (r_key == i_rd_data) begin
                    n_status = (r_cmd == skse_pkg::CMD_INSERT) ? skse_pkg::ST_PRESENT
                                                               : skse_pkg::ST_FOUND;
                    n_index  = CW'(r_mid);
                    n_state  = S_DONE;
                end else if (r_key < i_rd_data) begin
                    n_hi    = CW'(r_mid);
                    n_ins   = CW'(r_mid);
                    n_state = S_SRCH_RD;
                end else begin
                    n_lo    = CW'(r_mid) + CW'(1);
                    n_ins   = CW'(r_mid) + CW'(1);
                    n_state = S_SRCH_RD;
                end
            end

            S_SHIFT: begin
                // read one entry ahead, write the previous one behind it
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_wr_ptr;
                    o_wr_data = i_rd_data;
                    n_wr_ptr  = r_up ? (r_wr_ptr - AW'(1)) : (r_wr_ptr + AW'(1));
                end
                if (r_moves != '0) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_rd_ptr;
                    n_rd_ptr  = r_up ? (r_rd_ptr - AW'(1)) : (r_rd_ptr + AW'(1));
                    n_moves   = r_moves - CW'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if ((r_moves == '0) && !r_pend) begin
                    if (r_up) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = AW'(r_ins);
                        o_wr_data = r_key;
                        n_count   = r_count + CW'(1);
                    end else begin
                        n_count = r_count - CW'(r_len);
                    end
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_len    <= n_len;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_ins    <= n_ins;
        r_mid    <= n_mid;
        r_status <= n_status;
        r_index  <= n_index;
        r_rd_ptr <= n_rd_ptr;
        r_wr_ptr <= n_wr_ptr;
        r_moves  <= n_moves;
        r_pend   <= n_pend;
        r_up     <= n_up;
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.index  = skse_pkg::IDX_W'(r_index);
    assign o_res.count  = skse_pkg::IDX_W'(r_count);

endmodule

// ===== design/sorted_key_set_engine.sv =====
// Top level of the sorted key set engine: sequencer, key store and result register.
`timescale 1ns / 1ps

// Holds an ascending set of unique keys in a single-port-read store of CAPACITY
// entries and answers one request at a time; the request channel is ready only
// while the sequencer is idle, though a finished result may still wait in the
// output register. Insert and lookup run a binary search in which each probe is
// a store read, then a compare. An insert that adds a key then moves every
// larger entry up one place at one entry per cycle. A remove of a valid run
// moves the entries above it down; a zero-length remove, a run past the end or
// an unknown command goes from idle straight to the result. A stalled output
// holds the result in the sequencer until the result register can take it.
// The store has no reset; the key count is cleared by reset.
module sorted_key_set_engine #(
    parameter int CAPACITY = skse_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = skse_pkg::KEY_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    skse_req_if.sink   i_in,
    skse_res_if.source o_out
);

    localparam int AW = $clog2(CAPACITY);

    logic                res_valid;
    logic                res_take;
    skse_pkg::t_result   res;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [KEY_BITS-1:0] rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [KEY_BITS-1:0] wr_data;

    logic              r_out_valid;
    skse_pkg::t_result r_out;

    skse_ctrl #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in.valid),
        .o_req_ready (i_in.ready),
        .i_command   (i_in.command),
        .i_key       (i_in.key),
        .i_start     (i_in.start_index),
        .i_len       (i_in.remove_count),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    skse_key_store #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result register: refilled in the cycle the old result leaves
    assign res_take = res_valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out.status;
    assign o_out.index  = r_out.index;
    assign o_out.count  = r_out.count;

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request channel still ready after a request was taken");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == skse_pkg::ST_FULL))
            |-> (o_out.count == skse_pkg::IDX_W'(CAPACITY)))
        else $error("full reported with spare capacity");

    a_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && ((o_out.status == skse_pkg::ST_NOT_FOUND)
            || (o_out.status == skse_pkg::ST_FULL)
            || (o_out.status == skse_pkg::ST_RANGE)))
            |-> (o_out.index == '0))
        else $error("index given with a status that carries none");

endmodule

// ===== sim/skse_checker.sv =====
// Request/result checker for the sorted key set engine: shadow set, expected results, compare.
`timescale 1ns / 1ps

module skse_checker
    import skse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    skse_req_if  i_req,
    skse_res_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_key_count,
    output int   o_checked,
    output int   o_hits,
    output int   o_full_seen,
    output int   o_range_seen
);

    logic [KEY_IN_W-1:0] shadow_keys [CAPACITY_DEF];
    int                  shadow_count = 0;
    t_result             expected_results [$];

    int fails   = 0;
    int checked = 0;
    int hits    = 0;
    int fulls   = 0;
    int ranges  = 0;

    // Applies one request to the shadow set and returns the result it should produce.
    function automatic t_result apply_set_request(input logic [CMD_W-1:0]    cmd,
                                                  input logic [KEY_IN_W-1:0] key,
                                                  input int                  first,
                                                  input int                  run_len);
        t_result r;
        int      pos;
        int      i;
        bit      held;
        r.status = ST_RANGE;
        r.index  = '0;
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] < key)
            pos++;
        held = (pos < shadow_count) && (shadow_keys[pos] == key);
        case (cmd)
            CMD_INSERT: begin
                if (held) begin
                    r.status = ST_PRESENT;
                    r.index  = pos[IDX_W-1:0];
                end else if (shadow_count >= CAPACITY_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_keys[i] = shadow_keys[i-1];
                    shadow_keys[pos] = key;
                    shadow_count++;
                    r.status = ST_ADDED;
                    r.index  = pos[IDX_W-1:0];
                end
            end
            CMD_LOOKUP: begin
                if (held) begin
                    r.status = ST_FOUND;
                    r.index  = pos[IDX_W-1:0];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            CMD_REMOVE: begin
                if (run_len == 0) begin
                    r.status = ST_ADDED;
                end else if (first + run_len <= shadow_count) begin
                    for (i = first; i + run_len < shadow_count; i++)
                        shadow_keys[i] = shadow_keys[i + run_len];
                    shadow_count -= run_len;
                    r.status = ST_ADDED;
                end
            end
            default: ;
        endcase
        r.count = shadow_count[IDX_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_results.delete();
        end else begin
            // results first: a request accepted on this edge cannot have its result yet
            if (i_res.valid && i_res.ready) begin
                got.status = i_res.status;
                got.index  = i_res.index;
                got.count  = i_res.count;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, none outstanding: status %0d index %0d count %0d",
                             $time, got.status, got.index, got.count);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (got !== want) begin
                        $display("%0t: mismatch: expected status %0d index %0d count %0d, got status %0d index %0d count %0d",
                                 $time, want.status, want.index, want.count,
                                 got.status, got.index, got.count);
                        fails++;
                    end
                    if (want.status == ST_PRESENT || want.status == ST_FOUND)
                        hits++;
                    if (want.status == ST_FULL)
                        fulls++;
                    if (want.status == ST_RANGE)
                        ranges++;
                end
            end
            if (i_req.valid && i_req.ready)
                expected_results.push_back(apply_set_request(i_req.command, i_req.key,
                                                             int'(i_req.start_index),
                                                             int'(i_req.remove_count)));
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
        o_key_count  <= shadow_count;
        o_checked    <= checked;
        o_hits       <= hits;
        o_full_seen  <= fulls;
        o_range_seen <= ranges;
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the sorted key set engine testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import skse_pkg::*;

    localparam int               N_RANDOM     = 1800;
    localparam int               CYCLE_LIMIT  = 3_000_000;
    localparam int               DRAIN_CYCLES = 300;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

    localparam int EP_FILL  = 0;
    localparam int EP_MIXED = 1;
    localparam int EP_DRAIN = 2;

    localparam int RX_FREE   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_MOSTLY = 2;
    localparam int RX_BURSTY = 3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int cycles     = 0;
    int sent       = 0;
    int burst_left = 1;
    int fail_count;
    int pending;
    int key_count;
    int checked;
    int hits;
    int full_seen;
    int range_seen;

    logic [KEY_IN_W-1:0] recent_keys [$];

    skse_req_if req_ch ();
    skse_res_if res_ch ();

    sorted_key_set_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    skse_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_key_count  (key_count),
        .o_checked    (checked),
        .o_hits       (hits),
        .o_full_seen  (full_seen),
        .o_range_seen (range_seen)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: the stall pattern switches to a randomly chosen mode after each span of random length.
    initial begin : result_stalls
        int mode;
        int span;
        int k;
        res_ch.ready <= 1'b0;
        forever begin
            mode = $urandom_range(RX_FREE, RX_BURSTY);
            span = $urandom_range(32, 256);
            for (k = 0; k < span; k++) begin
                @(posedge i_clk);
                case (mode)
                    RX_FREE:   res_ch.ready <= 1'b1;
                    RX_COIN:   res_ch.ready <= ($urandom_range(0, 1) != 0);
                    RX_MOSTLY: res_ch.ready <= ($urandom_range(0, 7) != 0);
                    default:   res_ch.ready <= ((k % 16) >= 12);
                endcase
            end
        end
    end

    task automatic send_request(input logic [CMD_W-1:0]    cmd,
                                input logic [KEY_IN_W-1:0] key,
                                input logic [IDX_W-1:0]    first,
                                input logic [IDX_W-1:0]    run_len);
        int gap;
        req_ch.valid        <= 1'b1;
        req_ch.command      <= cmd;
        req_ch.key          <= key;
        req_ch.start_index  <= first;
        req_ch.remove_count <= run_len;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        sent++;
        if (cmd == CMD_INSERT) begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 64)
                void'(recent_keys.pop_front());
        end
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Keys drawn from recently inserted ones (and their neighbours), edge values or anywhere.
    function automatic logic [KEY_IN_W-1:0] pick_key(input int recent_pct);
        logic [KEY_IN_W-1:0] k;
        int                  roll;
        roll = $urandom_range(0, 99);
        if (recent_keys.size() != 0 && roll < recent_pct) begin
            k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            case ($urandom_range(0, 9))
                0:       k = k + 1'b1;
                1:       k = k - 1'b1;
                default: ;
            endcase
        end else if (roll >= 92) begin
            case ($urandom_range(0, 5))
                0:       k = 32'h0000_0000;
                1:       k = 32'h0000_0001;
                2:       k = 32'h7FFF_FFFF;
                3:       k = 32'h8000_0000;
                4:       k = 32'hFFFF_FFFE;
                default: k = 32'hFFFF_FFFF;
            endcase
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    task automatic issue_random(input int episode);
        int                  roll;
        int                  cnt;
        int                  first;
        int                  run_len;
        logic [CMD_W-1:0]    cmd;
        logic [KEY_IN_W-1:0] key;
        roll    = $urandom_range(0, 99);
        cnt     = key_count;
        first   = $urandom_range(0, 511);
        run_len = $urandom_range(0, 511);
        case (episode)
            EP_FILL:  cmd = (roll < 90) ? CMD_INSERT : (roll < 97) ? CMD_LOOKUP :
                            (roll < 99) ? CMD_REMOVE : CMD_UNUSED;
            EP_MIXED: cmd = (roll < 40) ? CMD_INSERT : (roll < 75) ? CMD_LOOKUP :
                            (roll < 97) ? CMD_REMOVE : CMD_UNUSED;
            default:  cmd = (roll < 55) ? CMD_REMOVE : (roll < 80) ? CMD_INSERT :
                            (roll < 97) ? CMD_LOOKUP : CMD_UNUSED;
        endcase
        if (cmd == CMD_LOOKUP)
            key = pick_key(60);
        else if (episode == EP_FILL)
            key = pick_key(8);
        else
            key = pick_key(40);
        // most removes are aimed at the set as it stood one request ago; the rest are noise
        if (cmd == CMD_REMOVE && $urandom_range(0, 9) < 8) begin
            first = $urandom_range(0, cnt);
            case ($urandom_range(0, 7))
                0, 1:    run_len = $urandom_range(0, cnt - first);
                2: begin
                    first   = 0;
                    run_len = cnt;
                end
                3:       run_len = cnt - first + 1;
                default: run_len = $urandom_range(1, 4);
            endcase
        end
        send_request(cmd, key, first[IDX_W-1:0], run_len[IDX_W-1:0]);
    endtask

    initial begin : stimulus
        int episode;
        int span;
        int k;
        int directed;
        int roll;
        req_ch.valid        <= 1'b0;
        req_ch.command      <= CMD_INSERT;
        req_ch.key          <= '0;
        req_ch.start_index  <= '0;
        req_ch.remove_count <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty set corners, unknown command, then a small set worked by hand
        send_request(CMD_LOOKUP, 32'h0000_0000, 9'd0,   9'd0);
        send_request(CMD_REMOVE, 32'h0000_0000, 9'd0,   9'd0);
        send_request(CMD_REMOVE, 32'h0000_0000, 9'd0,   9'd1);
        send_request(CMD_REMOVE, 32'hFFFF_FFFF, 9'h1FF, 9'h1FF);
        send_request(CMD_UNUSED, 32'h1234_5678, 9'd0,   9'd0);
        send_request(CMD_INSERT, 32'h0000_0000, 9'd0,   9'd0);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 9'h1FF, 9'h1FF);
        send_request(CMD_INSERT, 32'h8000_0000, 9'd0,   9'd0);
        send_request(CMD_INSERT, 32'h0000_0000, 9'd0,   9'd0);
        send_request(CMD_INSERT, 32'h0000_0001, 9'd0,   9'd0);
        send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 9'd0,   9'd0);
        send_request(CMD_LOOKUP, 32'h7FFF_FFFF, 9'd0,   9'd0);
        send_request(CMD_LOOKUP, 32'h0000_0000, 9'h1FF, 9'h1FF);
        send_request(CMD_REMOVE, 32'h0000_0000, 9'd1,   9'd2);
        send_request(CMD_REMOVE, 32'h0000_0000, 9'd2,   9'd0);
        send_request(CMD_REMOVE, 32'h0000_0000, 9'd1,   9'd2);
        send_request(CMD_INSERT, 32'hFFFF_FFFE, 9'd0,   9'd0);
        send_request(CMD_LOOKUP, 32'h8000_0000, 9'd0,   9'd0);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF, 9'h1FF, 9'h1FF);
        send_request(CMD_REMOVE, 32'h0000_0000, 9'd0,   9'd3);
        send_request(CMD_INSERT, 32'hA5A5_A5A5, 9'h1FF, 9'h1FF);
        send_request(CMD_REMOVE, 32'h0000_0000, 9'd256, 9'd256);
        directed = sent;

        // first episode fills the set so that full refusals and long shifts come early
        episode = EP_FILL;
        while (sent - directed < N_RANDOM) begin
            span = (episode == EP_FILL) ? 400 : (episode == EP_MIXED) ? 150 : 40;
            for (k = 0; k < span && sent - directed < N_RANDOM; k++)
                issue_random(episode);
            roll    = $urandom_range(0, 9);
            episode = (roll < 3) ? EP_FILL : (roll < 7) ? EP_MIXED : EP_DRAIN;
        end
        req_ch.valid <= 1'b0;

        do
            @(posedge i_clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d directed), %0d results checked in %0d cycles",
                 sent, directed, checked, cycles);
        $display("Keys hit %0d, inserts refused as full %0d, range errors %0d, failures %0d",
                 hits, full_seen, range_seen, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/skse_pkg.sv
design/skse_if.sv
design/skse_key_store.sv
design/skse_ctrl.sv
design/sorted_key_set_engine.sv
sim/skse_checker.sv
sim/testbench.sv
